/* src/wfn_pkg.sv */
// ----------------------------------------------------------------------------
// Window first negative package
// Shared widths, defaults and types for the sliding window first negative unit.
// ----------------------------------------------------------------------------
package wfn_pkg;

  localparam int WINDOW_MAX_DEF = 64;
  localparam int SAMPLE_W       = 32;
  localparam int CFG_W          = 7;

  // Per-word commands that every cell of the queue chain sees.
  typedef struct packed {
    logic pop;
    logic push;
    logic clear;
  } cell_ctl_t;

  // One result word.
  typedef struct packed {
    logic [SAMPLE_W-1:0] first_negative;
    logic                found;
    logic                last_window;
  } result_t;

endpackage

/* src/wfn_cell.sv */
// ----------------------------------------------------------------------------
// Queue cell
// One slot of the shift-register queue of negative samples and their positions.
// ----------------------------------------------------------------------------
module wfn_cell #(
  parameter int PosW = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wfn_pkg::cell_ctl_t           ctl_i,
  input  logic                         prev_valid_i,
  input  logic                         next_valid_i,
  input  logic [wfn_pkg::SAMPLE_W-1:0] next_value_i,
  input  logic [PosW-1:0]              next_pos_i,
  input  logic [wfn_pkg::SAMPLE_W-1:0] new_value_i,
  input  logic [PosW-1:0]              new_pos_i,
  output logic                         valid_o,
  output logic [wfn_pkg::SAMPLE_W-1:0] value_o,
  output logic [PosW-1:0]              pos_o,
  output logic                         fill_valid_o,
  output logic [wfn_pkg::SAMPLE_W-1:0] fill_value_o
);
  import wfn_pkg::*;

  logic                valid_q, valid_d;
  logic [SAMPLE_W-1:0] value_q, value_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic                tail;

  always_comb begin
    tail    = ctl_i.pop ? (valid_q && !next_valid_i) : (!valid_q && prev_valid_i);
    valid_d = valid_q;
    value_d = value_q;
    pos_d   = pos_q;
    if (ctl_i.push && tail) begin
      valid_d = 1'b1;
      value_d = new_value_i;
      pos_d   = new_pos_i;
    end else if (ctl_i.pop) begin
      valid_d = next_valid_i;
      value_d = next_value_i;
      pos_d   = next_pos_i;
    end
  end

  assign fill_valid_o = valid_d;
  assign fill_value_o = value_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d && !ctl_i.clear;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pos_q   <= pos_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign pos_o   = pos_q;

endmodule

/* src/wfn_obuf.sv */
// ----------------------------------------------------------------------------
// Output buffer
// Output register with a skid stage so the input side keeps flowing.
// ----------------------------------------------------------------------------
module wfn_obuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  wfn_pkg::result_t res_i,
  output logic             ready_o,
  output logic             valid_o,
  output wfn_pkg::result_t res_o,
  input  logic             take_ready_i
);
  import wfn_pkg::*;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_free;

  assign out_free = !out_valid_q || take_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || load_i;
      skid_valid_q <= 1'b0;
    end else if (load_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (load_i) begin
      skid_q <= res_i;
    end
  end

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;

endmodule

/* src/window_first_negative_unit.sv */
// ----------------------------------------------------------------------------
// Window first negative unit
// Reports the earliest negative sample of each sliding window of a stream.
// ----------------------------------------------------------------------------
// The unit takes one sample word per clock while s_axis_tready is high and
// registers a result once a window is full; negative samples sit in a row
// of WINDOW_MAX shift cells, the oldest in the first cell, and the window
// age of that entry is checked and the row shifted in the same cycle as the
// new sample enters. A two-deep output buffer admits one more sample while
// a result waits. No reset sweep; tlast ends a sequence and empties the row.
module window_first_negative_unit #(
  parameter int WINDOW_MAX = wfn_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wfn_pkg::CFG_W-1:0]    cfg_wdata_i,    // window_size
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [wfn_pkg::SAMPLE_W-1:0] s_axis_tdata,   // sample
  input  logic                         s_axis_tlast,   // last_sample
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [wfn_pkg::SAMPLE_W-1:0] m_axis_tdata,   // first_negative
  output logic [0:0]                   m_axis_tuser,   // found
  output logic                         m_axis_tlast    // last_window
);
  import wfn_pkg::*;

  localparam int PosW = $clog2(2 * WINDOW_MAX);
  localparam int CntW = $clog2(WINDOW_MAX + 1);
  localparam int CmpW = (CntW > CFG_W) ? CntW + 1 : CFG_W + 1;

  logic [CFG_W-1:0]    window_q;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [CntW-1:0]     seen_q, seen_d, seen_inc;
  logic [CmpW-1:0]     win_ext;
  logic [CntW-1:0]     win_eff;
  logic [PosW-1:0]     age;
  logic                accept, produce, obuf_ready;
  cell_ctl_t           ctl;
  result_t             res, res_out;

  logic [WINDOW_MAX-1:0] cell_valid;
  logic [WINDOW_MAX-1:0] fill_valid;
  logic [SAMPLE_W-1:0]   cell_value [WINDOW_MAX];
  logic [PosW-1:0]       cell_pos   [WINDOW_MAX];
  logic [SAMPLE_W-1:0]   fill_value [WINDOW_MAX];

  assign accept        = s_axis_tvalid && obuf_ready;
  assign s_axis_tready = obuf_ready;

  always_comb begin
    win_ext = CmpW'(window_q);
    if (win_ext == '0) begin
      win_eff = CntW'(1);
    end else if (win_ext > CmpW'(WINDOW_MAX)) begin
      win_eff = CntW'(WINDOW_MAX);
    end else begin
      win_eff = CntW'(window_q);
    end
  end

  assign age       = (pos_q >= cell_pos[0]) ? (pos_q - cell_pos[0])
                                            : (pos_q - cell_pos[0] + PosW'(2 * WINDOW_MAX));
  assign ctl.pop   = accept && cell_valid[0] && (age >= PosW'(win_eff));
  assign ctl.push  = accept && s_axis_tdata[SAMPLE_W-1];
  assign ctl.clear = accept && s_axis_tlast;

  assign seen_inc = (seen_q == CntW'(WINDOW_MAX)) ? seen_q : seen_q + CntW'(1);
  assign produce  = accept && (seen_inc >= win_eff);

  always_comb begin
    pos_d  = pos_q;
    seen_d = seen_q;
    if (accept) begin
      if (s_axis_tlast || (pos_q == PosW'(2 * WINDOW_MAX - 1))) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
      seen_d = s_axis_tlast ? '0 : seen_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= CFG_W'(1);
      pos_q    <= '0;
      seen_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      pos_q  <= pos_d;
      seen_q <= seen_d;
    end
  end

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    logic                prev_v, next_v;
    logic [SAMPLE_W-1:0] next_val;
    logic [PosW-1:0]     next_p;

    if (g == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = cell_valid[g-1];
    end

    if (g == WINDOW_MAX - 1) begin : g_last
      assign next_v   = 1'b0;
      assign next_val = '0;
      assign next_p   = '0;
    end else begin : g_inner
      assign next_v   = cell_valid[g+1];
      assign next_val = cell_value[g+1];
      assign next_p   = cell_pos[g+1];
    end

    wfn_cell #(
      .PosW(PosW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .prev_valid_i(prev_v),
      .next_valid_i(next_v),
      .next_value_i(next_val),
      .next_pos_i  (next_p),
      .new_value_i (s_axis_tdata),
      .new_pos_i   (pos_q),
      .valid_o     (cell_valid[g]),
      .value_o     (cell_value[g]),
      .pos_o       (cell_pos[g]),
      .fill_valid_o(fill_valid[g]),
      .fill_value_o(fill_value[g])
    );
  end

  assign res.found          = fill_valid[0];
  assign res.first_negative = fill_valid[0] ? fill_value[0] : '0;
  assign res.last_window    = s_axis_tlast;

  wfn_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (produce),
    .res_i       (res),
    .ready_o     (obuf_ready),
    .valid_o     (m_axis_tvalid),
    .res_o       (res_out),
    .take_ready_i(m_axis_tready)
  );

  assign m_axis_tdata    = res_out.first_negative;
  assign m_axis_tuser[0] = res_out.found;
  assign m_axis_tlast    = res_out.last_window;

  a_queue_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid & (cell_valid + WINDOW_MAX'(1))) == '0))
    else $error("queue cells are not filled from the head without gaps");

  a_fill_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((fill_valid & (fill_valid + WINDOW_MAX'(1))) == '0))
    else $error("next queue fill leaves a gap");

  a_found_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] ? m_axis_tdata[SAMPLE_W-1] : (m_axis_tdata == '0)))
    else $error("result value disagrees with its found flag");

  a_seq_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (pos_q == '0 && seen_q == '0 && cell_valid == '0))
    else $error("sequence state not cleared after the last word");

endmodule
